FILE: hw/rtl/dlvps_pkg.sv
// dlvps_pkg: shared constants, codes and types of the dc link voltage pi step
// used by dlvps_gain_mul, dlvps_div and dc_link_voltage_pi_step; no dependencies

package dlvps_pkg;

   // default signal width, signed q32.16 at 48 bits
   localparam int DATA_WIDTH_DEF = 48;

   // fixed field widths
   localparam int GAIN_W      = 48;   // unsigned q16.32 gains
   localparam int GAIN_FRAC_W = 32;   // fraction bits of a gain
   localparam int NOM_W       = 47;   // nominal voltage register
   localparam int FRAC_W      = 16;   // fraction bits of a signal
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 48;

   // gain multiplier works on 16-bit slices of the gain
   localparam int CHUNK_W     = 16;
   localparam int GAIN_CHUNKS = GAIN_W / CHUNK_W;

   // nominal voltage after reset: 1.0 in q32.16
   localparam logic [NOM_W-1:0] NOM_RESET = 47'd65536;

   // item kinds
   localparam logic OP_STEP = 1'b0;
   localparam logic OP_INIT = 1'b1;

   // register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_KP_GAIN     = 2'd0,
      CSR_KI_DT       = 2'd1,
      CSR_DT_OVER_CAP = 2'd2,
      CSR_V_NOMINAL   = 2'd3
   } csr_index_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_MUL_KP,
      ST_MUL_KI,
      ST_DIV,
      ST_DIFF,
      ST_MUL_DT,
      ST_DONE
   } seq_state_type;

   // command to an iterative unit: start pulse and sign of the operand
   typedef struct packed {
      logic start;
      logic neg;
   } unit_cmd_type;

endpackage

FILE: hw/rtl/dlvps_gain_mul.sv
// dlvps_gain_mul: iterative magnitude times q16.32 gain, one 16-bit gain slice per cycle
// rounds to q32.16 (ties away from zero) and saturates; uses dlvps_pkg

module dlvps_gain_mul #(
   parameter int DATA_WIDTH = dlvps_pkg::DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dlvps_pkg::unit_cmd_type      cmd,
   input  logic [DATA_WIDTH-1:0]        mag,
   input  logic [dlvps_pkg::GAIN_W-1:0] gain,
   output logic [DATA_WIDTH-1:0]        result,
   output logic                         done
);

   localparam int ACC_W  = DATA_WIDTH + dlvps_pkg::GAIN_W;
   localparam int PART_W = DATA_WIDTH + dlvps_pkg::CHUNK_W;
   localparam int RES_W  = ACC_W - dlvps_pkg::GAIN_FRAC_W;
   localparam int IDX_W  = $clog2(dlvps_pkg::GAIN_CHUNKS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(dlvps_pkg::GAIN_CHUNKS - 1);
   localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (dlvps_pkg::GAIN_FRAC_W - 1);
   localparam logic [DATA_WIDTH-1:0] SIG_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] SIG_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic [RES_W-1:0] POS_LIM = RES_W'(SIG_MAX);
   localparam logic [RES_W-1:0] NEG_LIM = RES_W'(SIG_MAX) + RES_W'(1);

   logic                         busy_ff, busy_in;
   logic                         fin_ff, fin_in;
   logic                         done_ff, done_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic [ACC_W-1:0]             acc_ff, acc_in;
   logic [DATA_WIDTH-1:0]        mag_ff, mag_in;
   logic [dlvps_pkg::GAIN_W-1:0] gain_ff, gain_in;
   logic                         neg_ff, neg_in;
   logic [DATA_WIDTH-1:0]        res_ff, res_in;
   logic [dlvps_pkg::CHUNK_W-1:0] chunk;
   logic [PART_W-1:0]            part;
   logic [ACC_W-1:0]             part_shifted;

   // sign and magnitude to a saturated signed signal
   function automatic logic [DATA_WIDTH-1:0] from_mag(logic neg, logic [RES_W-1:0] m);
      if (!neg) begin
         from_mag = (m > POS_LIM) ? SIG_MAX : m[DATA_WIDTH-1:0];
      end else begin
         from_mag = (m > NEG_LIM) ? SIG_MIN : DATA_WIDTH'(-m);
      end
   endfunction

   // one partial product per cycle, weighted by its slice position
   always_comb begin
      chunk        = gain_ff[idx_ff*dlvps_pkg::CHUNK_W +: dlvps_pkg::CHUNK_W];
      part         = PART_W'(mag_ff) * PART_W'(chunk);
      part_shifted = ACC_W'(part) << (idx_ff * dlvps_pkg::CHUNK_W);
   end

   // slice counter, accumulator and final rounding
   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = done_ff;
      idx_in  = idx_ff;
      acc_in  = acc_ff;
      mag_in  = mag_ff;
      gain_in = gain_ff;
      neg_in  = neg_ff;
      res_in  = res_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         idx_in  = '0;
         acc_in  = ROUND_HALF;
         mag_in  = mag;
         gain_in = gain;
         neg_in  = cmd.neg;
      end else if (busy_ff) begin
         acc_in = acc_ff + part_shifted;
         if (idx_ff == LAST_IDX) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end else if (fin_ff) begin
         res_in  = from_mag(neg_ff, acc_ff[ACC_W-1:dlvps_pkg::GAIN_FRAC_W]);
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      mag_ff  <= mag_in;
      gain_ff <= gain_in;
      neg_ff  <= neg_in;
      res_ff  <= res_in;
   end

   assign result = res_ff;
   assign done   = done_ff;

endmodule

FILE: hw/rtl/dlvps_div.sv
// dlvps_div: bit-serial restoring divider, (magnitude << 16) / divisor, one quotient bit a cycle
// truncates toward zero and saturates to the signal range; uses dlvps_pkg

module dlvps_div #(
   parameter int DATA_WIDTH = dlvps_pkg::DATA_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dlvps_pkg::unit_cmd_type cmd,
   input  logic [DATA_WIDTH-1:0]   mag,
   input  logic [DATA_WIDTH-1:0]   divisor,
   output logic [DATA_WIDTH-1:0]   result,
   output logic                    done
);

   localparam int Q_W   = DATA_WIDTH + dlvps_pkg::FRAC_W;
   localparam int CNT_W = $clog2(Q_W + 1);
   localparam logic [DATA_WIDTH-1:0] SIG_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] SIG_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic [Q_W-1:0] POS_LIM = Q_W'(SIG_MAX);
   localparam logic [Q_W-1:0] NEG_LIM = Q_W'(SIG_MAX) + Q_W'(1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [Q_W-1:0]        quo_ff, quo_in;
   logic [DATA_WIDTH-2:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] div_ff, div_in;
   logic                  neg_ff, neg_in;
   logic [DATA_WIDTH-1:0] res_ff, res_in;
   logic [DATA_WIDTH:0]   trial;
   logic [DATA_WIDTH-1:0] shifted;

   // sign and magnitude to a saturated signed signal
   function automatic logic [DATA_WIDTH-1:0] from_mag(logic neg, logic [Q_W-1:0] m);
      if (!neg) begin
         from_mag = (m > POS_LIM) ? SIG_MAX : m[DATA_WIDTH-1:0];
      end else begin
         from_mag = (m > NEG_LIM) ? SIG_MIN : DATA_WIDTH'(-m);
      end
   endfunction

   // trial subtract of the divisor from the shifted partial remainder
   always_comb begin
      shifted = {rem_ff, quo_ff[Q_W-1]};
      trial   = {1'b0, shifted} - {1'b0, div_ff};
   end

   // step sequencing: shift one dividend bit into the remainder, shift one quotient bit in
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;
      res_in  = res_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = CNT_W'(Q_W);
         quo_in  = {mag, {dlvps_pkg::FRAC_W{1'b0}}};
         rem_in  = '0;
         div_in  = divisor;
         neg_in  = cmd.neg;
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            cnt_in = cnt_ff - CNT_W'(1);
            quo_in = {quo_ff[Q_W-2:0], ~trial[DATA_WIDTH]};
            rem_in = trial[DATA_WIDTH] ? shifted[DATA_WIDTH-2:0] : trial[DATA_WIDTH-2:0];
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = from_mag(neg_ff, quo_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign result = res_ff;
   assign done   = done_ff;

endmodule

FILE: hw/rtl/dc_link_voltage_pi_step.sv
// dc_link_voltage_pi_step: dc link pi controller with capacitor model, one time step per beat
// sequencer, state and config registers; uses dlvps_pkg, dlvps_gain_mul and dlvps_div
//
//   channel | direction | payload
//   req     | in        | tdata: power; tuser: op (0 step, 1 initialize)
//   rsp     | out       | tdata: dc_voltage, source_current, inverter_current; tuser: divide_fault
//   csr     | in        | csr_index selects kp_gain, ki_dt, dt_over_cap, v_nominal
//
// one item at a time: a step runs the bit-serial divider (one quotient bit per cycle)
// alongside the shared gain multiplier (three products per step); an initialize runs
// the divider alone.
// synchronous reset clears state, gains and result valid; v_nominal resets to 1.0.
// a finished beat waits in the result register; the next item is taken once it is loaded.

module dc_link_voltage_pi_step #(
   parameter int DATA_WIDTH = dlvps_pkg::DATA_WIDTH_DEF,
   localparam int REQ_DATA_W = ((DATA_WIDTH + 7) / 8) * 8,
   localparam int RSP_DATA_W = ((3 * DATA_WIDTH + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [REQ_DATA_W-1:0]            req_tdata,   // power
   input  logic                             req_tuser,   // op
   // result channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [RSP_DATA_W-1:0]            rsp_tdata,   // dc_voltage, source_current, inverter_current
   output logic                             rsp_tuser,   // divide_fault
   // config write port
   input  logic                             csr_wr_en,
   input  logic [dlvps_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [dlvps_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int W = DATA_WIDTH;
   localparam int CMP_W = (W > dlvps_pkg::NOM_W) ? W : dlvps_pkg::NOM_W;
   localparam logic [W-1:0] SIG_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] SIG_MIN = {1'b1, {(W-1){1'b0}}};

   // config registers
   logic [dlvps_pkg::GAIN_W-1:0] kp_gain_ff, kp_gain_in;
   logic [dlvps_pkg::GAIN_W-1:0] ki_dt_ff, ki_dt_in;
   logic [dlvps_pkg::GAIN_W-1:0] dt_over_cap_ff, dt_over_cap_in;
   logic [dlvps_pkg::NOM_W-1:0]  v_nominal_ff, v_nominal_in;

   // model state
   logic [W-1:0] voltage_next_ff, voltage_next_in;
   logic [W-1:0] integrator_next_ff, integrator_next_in;

   // sequencer and working registers
   dlvps_pkg::seq_state_type state_ff, state_in;
   logic         op_ff, op_in;
   logic [W-1:0] power_ff, power_in;
   logic [W-1:0] volt_ff, volt_in;
   logic [W-1:0] integ_ff, integ_in;
   logic [W-1:0] emag_ff, emag_in;
   logic         eneg_ff, eneg_in;
   logic [W-1:0] src_ff, src_in;
   logic [W-1:0] inv_ff, inv_in;

   // result register
   logic         rsp_tvalid_ff, rsp_tvalid_in;
   logic [W-1:0] rsp_volt_ff, rsp_volt_in;
   logic [W-1:0] rsp_src_ff, rsp_src_in;
   logic [W-1:0] rsp_inv_ff, rsp_inv_in;
   logic         rsp_fault_ff, rsp_fault_in;

   // datapath wires
   logic [CMP_W-1:0] nom_wide;
   logic [W-1:0]     nom;
   logic             volt_fault;
   logic [W:0]       e_sum;
   logic             e_neg;
   logic [W-1:0]     e_mag;
   logic [W:0]       d_sum;
   logic             d_neg;
   logic [W-1:0]     d_mag;
   logic [W-1:0]     power_mag;
   logic [W-1:0]     inv_val;
   logic             rsp_load;

   // unit connections: shared gain multiplier and divider
   dlvps_pkg::unit_cmd_type      mul_cmd;
   logic [W-1:0]                 mul_mag;
   logic [dlvps_pkg::GAIN_W-1:0] mul_gain;
   logic [W-1:0]                 mul_res;
   logic                         mul_done;
   dlvps_pkg::unit_cmd_type      div_cmd;
   logic [W-1:0]                 div_res;
   logic                         div_done;

   // signed add saturated to the signal range
   function automatic logic [W-1:0] sat_add(logic [W-1:0] a, logic [W-1:0] b);
      logic [W:0] s;
      s = {a[W-1], a} + {b[W-1], b};
      if (s[W] != s[W-1]) begin
         sat_add = s[W] ? SIG_MIN : SIG_MAX;
      end else begin
         sat_add = s[W-1:0];
      end
   endfunction

   // nominal voltage clamped to the signal range, and the exact differences
   always_comb begin
      nom_wide   = CMP_W'(v_nominal_ff);
      nom        = (nom_wide > CMP_W'(SIG_MAX)) ? SIG_MAX : W'(nom_wide);
      volt_fault = volt_ff[W-1] | (volt_ff == '0);
      e_sum      = {nom[W-1], nom} - {volt_ff[W-1], volt_ff};
      e_neg      = e_sum[W];
      e_mag      = e_neg ? W'(-e_sum) : e_sum[W-1:0];
      d_sum      = {src_ff[W-1], src_ff} - {inv_ff[W-1], inv_ff};
      d_neg      = d_sum[W];
      d_mag      = d_neg ? W'(-d_sum) : d_sum[W-1:0];
      power_mag  = power_ff[W-1] ? W'(-power_ff) : power_ff;
      inv_val    = volt_fault ? '0 : div_res;
   end

   // config writes
   always_comb begin
      kp_gain_in     = kp_gain_ff;
      ki_dt_in       = ki_dt_ff;
      dt_over_cap_in = dt_over_cap_ff;
      v_nominal_in   = v_nominal_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            dlvps_pkg::CSR_KP_GAIN:     kp_gain_in     = csr_wdata;
            dlvps_pkg::CSR_KI_DT:       ki_dt_in       = csr_wdata;
            dlvps_pkg::CSR_DT_OVER_CAP: dt_over_cap_in = csr_wdata;
            dlvps_pkg::CSR_V_NOMINAL:   v_nominal_in   = csr_wdata[dlvps_pkg::NOM_W-1:0];
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dlvps_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = dlvps_pkg::ST_SETUP;
         end
         dlvps_pkg::ST_SETUP: begin
            state_in = (op_ff == dlvps_pkg::OP_INIT) ? dlvps_pkg::ST_DIV : dlvps_pkg::ST_MUL_KP;
         end
         dlvps_pkg::ST_MUL_KP: begin
            if (mul_done) state_in = dlvps_pkg::ST_MUL_KI;
         end
         dlvps_pkg::ST_MUL_KI: begin
            if (mul_done) state_in = dlvps_pkg::ST_DIV;
         end
         dlvps_pkg::ST_DIV: begin
            if (volt_fault || div_done) begin
               state_in = (op_ff == dlvps_pkg::OP_INIT) ? dlvps_pkg::ST_DONE : dlvps_pkg::ST_DIFF;
            end
         end
         dlvps_pkg::ST_DIFF: begin
            state_in = dlvps_pkg::ST_MUL_DT;
         end
         dlvps_pkg::ST_MUL_DT: begin
            if (mul_done) state_in = dlvps_pkg::ST_DONE;
         end
         dlvps_pkg::ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) state_in = dlvps_pkg::ST_IDLE;
         end
         default: state_in = dlvps_pkg::ST_IDLE;
      endcase
   end

   // unit commands and operand selection
   always_comb begin
      mul_cmd  = '0;
      div_cmd  = '0;
      mul_mag  = emag_ff;
      mul_gain = kp_gain_ff;
      rsp_load = 1'b0;
      unique case (state_ff)
         dlvps_pkg::ST_SETUP: begin
            mul_cmd.start = (op_ff == dlvps_pkg::OP_STEP);
            mul_cmd.neg   = e_neg;
            mul_mag       = e_mag;
            mul_gain      = kp_gain_ff;
            div_cmd.start = !volt_fault;
            div_cmd.neg   = power_ff[W-1];
         end
         dlvps_pkg::ST_MUL_KP: begin
            mul_cmd.start = mul_done;
            mul_cmd.neg   = eneg_ff;
            mul_mag       = emag_ff;
            mul_gain      = ki_dt_ff;
         end
         dlvps_pkg::ST_DIFF: begin
            mul_cmd.start = 1'b1;
            mul_cmd.neg   = d_neg;
            mul_mag       = d_mag;
            mul_gain      = dt_over_cap_ff;
         end
         dlvps_pkg::ST_DONE: begin
            rsp_load = !rsp_tvalid_ff || rsp_tready;
         end
         default: begin
         end
      endcase
   end

   assign req_tready = (state_ff == dlvps_pkg::ST_IDLE);

   // working registers and state updates
   always_comb begin
      op_in              = op_ff;
      power_in           = power_ff;
      volt_in            = volt_ff;
      integ_in           = integ_ff;
      emag_in            = emag_ff;
      eneg_in            = eneg_ff;
      src_in             = src_ff;
      inv_in             = inv_ff;
      voltage_next_in    = voltage_next_ff;
      integrator_next_in = integrator_next_ff;
      unique case (state_ff)
         dlvps_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               power_in = req_tdata[W-1:0];
               volt_in  = (req_tuser == dlvps_pkg::OP_INIT) ? nom : voltage_next_ff;
               integ_in = integrator_next_ff;
            end
         end
         dlvps_pkg::ST_SETUP: begin
            emag_in = e_mag;
            eneg_in = e_neg;
         end
         dlvps_pkg::ST_MUL_KP: begin
            if (mul_done) src_in = sat_add(mul_res, integ_ff);
         end
         dlvps_pkg::ST_MUL_KI: begin
            if (mul_done) integrator_next_in = sat_add(integ_ff, mul_res);
         end
         dlvps_pkg::ST_DIV: begin
            if (volt_fault || div_done) begin
               inv_in = inv_val;
               // initialize: steady state around the nominal voltage
               if (op_ff == dlvps_pkg::OP_INIT) begin
                  src_in             = inv_val;
                  voltage_next_in    = volt_ff;
                  integrator_next_in = inv_val;
               end
            end
         end
         dlvps_pkg::ST_MUL_DT: begin
            if (mul_done) voltage_next_in = sat_add(volt_ff, mul_res);
         end
         default: begin
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_volt_in   = rsp_volt_ff;
      rsp_src_in    = rsp_src_ff;
      rsp_inv_in    = rsp_inv_ff;
      rsp_fault_in  = rsp_fault_ff;
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_volt_in   = volt_ff;
         rsp_src_in    = src_ff;
         rsp_inv_in    = inv_ff;
         rsp_fault_in  = volt_fault;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= dlvps_pkg::ST_IDLE;
         kp_gain_ff         <= '0;
         ki_dt_ff           <= '0;
         dt_over_cap_ff     <= '0;
         v_nominal_ff       <= dlvps_pkg::NOM_RESET;
         voltage_next_ff    <= '0;
         integrator_next_ff <= '0;
         rsp_tvalid_ff      <= 1'b0;
      end else begin
         state_ff           <= state_in;
         kp_gain_ff         <= kp_gain_in;
         ki_dt_ff           <= ki_dt_in;
         dt_over_cap_ff     <= dt_over_cap_in;
         v_nominal_ff       <= v_nominal_in;
         voltage_next_ff    <= voltage_next_in;
         integrator_next_ff <= integrator_next_in;
         rsp_tvalid_ff      <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      power_ff     <= power_in;
      volt_ff      <= volt_in;
      integ_ff     <= integ_in;
      emag_ff      <= emag_in;
      eneg_ff      <= eneg_in;
      src_ff       <= src_in;
      inv_ff       <= inv_in;
      rsp_volt_ff  <= rsp_volt_in;
      rsp_src_ff   <= rsp_src_in;
      rsp_inv_ff   <= rsp_inv_in;
      rsp_fault_ff <= rsp_fault_in;
   end

   // shared gain multiplier
   dlvps_gain_mul #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_gain_mul (
      .clock  (clock),
      .reset  (reset),
      .cmd    (mul_cmd),
      .mag    (mul_mag),
      .gain   (mul_gain),
      .result (mul_res),
      .done   (mul_done)
   );

   // power over voltage
   dlvps_div #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .cmd     (div_cmd),
      .mag     (power_mag),
      .divisor (volt_ff),
      .result  (div_res),
      .done    (div_done)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_inv_ff, rsp_src_ff, rsp_volt_ff});
   assign rsp_tuser  = rsp_fault_ff;

   // an accepted beat always starts the setup cycle
   a_accept_setup: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == dlvps_pkg::ST_SETUP)
      else $error("accepted beat did not enter setup");

   // a result only appears on leaving the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == dlvps_pkg::ST_DONE))
      else $error("result raised outside the done state");

   // a faulted result carries zero inverter current
   a_fault_zero_inv: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_inv_ff == '0)
      else $error("fault with nonzero inverter current");

   // initialize never runs the gain multiplier
   a_init_no_mul: assert property (@(posedge clock) disable iff (reset)
      state_ff != dlvps_pkg::ST_IDLE && op_ff == dlvps_pkg::OP_INIT |-> !mul_cmd.start)
      else $error("multiplier started on initialize");

   // the divider is never started on a non-positive voltage
   a_div_no_fault: assert property (@(posedge clock) disable iff (reset)
      div_cmd.start |-> !volt_fault)
      else $error("divider started with non-positive divisor");

endmodule
